// ===== design/fisr_pkg.sv =====
// Package for the fast inverse square root block.
// Holds the constants, the pipeline depths and the bit patterns shared by all files.
// Has no dependencies of its own.
package fisr_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] GUESS_MAGIC = 32'h5F37_59DF;
  localparam logic [WORD_W-1:0] CANON_QNAN  = 32'h7FC0_0000;
  localparam logic [WORD_W-1:0] F32_HALF    = 32'h3F00_0000;
  localparam logic [WORD_W-1:0] F32_THREE_HALVES = 32'h3FC0_0000;

  localparam int unsigned FMUL_STAGES = 3;
  localparam int unsigned FADD_STAGES = 4;
  localparam int unsigned GUESS_STAGES = 1;
  localparam int unsigned LATENCY =
    GUESS_STAGES + FMUL_STAGES + FMUL_STAGES + FADD_STAGES + FMUL_STAGES;
  localparam int unsigned R_DELAY = FMUL_STAGES + FMUL_STAGES + FADD_STAGES;

endpackage

// ===== design/fisr_in_if.sv =====
// Stream interface for the operand items of the fast inverse square root block.
// Depends on fisr_pkg for the word width.
interface fisr_in_if;
  logic                          valid;
  logic                          ready;
  logic [fisr_pkg::WORD_W-1:0]   operand_bits;

  modport source (output valid, output operand_bits, input ready);
  modport sink   (input valid, input operand_bits, output ready);
endinterface

// ===== design/fisr_out_if.sv =====
// Stream interface for the result items of the fast inverse square root block.
// Depends on fisr_pkg for the word width.
interface fisr_out_if;
  logic                          valid;
  logic                          ready;
  logic [fisr_pkg::WORD_W-1:0]   result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

// ===== design/fisr_fmul.sv =====
// Three-stage binary32 multiplier: product, normalisation, rounding to nearest even.
// Handles subnormals, infinities and NaNs; depends on fisr_pkg.
module fisr_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  typedef struct packed {
    logic [47:0]        prod;
    logic signed [10:0] e;
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
  } mul_s1_t;

  typedef struct packed {
    logic [47:0] m;
    logic        sticky;
    logic [7:0]  expf;
    logic        ovf;
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
  } mul_s2_t;

  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  mul_s1_t s1_nxt, s1_r;
  mul_s2_t s2_nxt, s2_r;
  logic [31:0] p_nxt, p_r;

  logic [7:0]  ea, eb, eae, ebe;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    ma  = {(ea != 8'd0), fa};
    mb  = {(eb != 8'd0), fb};
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    s1_nxt.prod = 48'(ma) * 48'(mb);
    s1_nxt.e    = signed'({3'b000, eae}) + signed'({3'b000, ebe}) - 11'sd127;
    s1_nxt.sign = a[31] ^ b[31];
    s1_nxt.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    s1_nxt.inf  = a_inf || b_inf;
    s1_nxt.zero = a_zero || b_zero;
  end

  logic [5:0]         lz;
  logic [5:0]         lsh;
  logic [5:0]         rsh;
  logic signed [10:0] rsw;
  logic signed [10:0] en_exp;

  always_comb begin
    lz     = clz48(s1_r.prod);
    en_exp = s1_r.e + 11'sd1 - signed'({5'b00000, lz});
    rsw    = -s1_r.e;
    lsh    = 6'd0;
    rsh    = 6'd0;
    s2_nxt.sign = s1_r.sign;
    s2_nxt.nan  = s1_r.nan;
    s2_nxt.inf  = s1_r.inf;
    s2_nxt.zero = s1_r.zero;
    if (s1_r.e >= 11'sd0) begin
      lsh = (signed'({5'b00000, lz}) < s1_r.e) ? lz : s1_r.e[5:0];
      s2_nxt.m      = s1_r.prod << lsh;
      s2_nxt.sticky = 1'b0;
    end else begin
      rsh = (rsw > 11'sd49) ? 6'd49 : rsw[5:0];
      s2_nxt.m      = s1_r.prod >> rsh;
      s2_nxt.sticky = |(s1_r.prod & ~(48'hFFFF_FFFF_FFFF << rsh));
    end
    s2_nxt.expf = s2_nxt.m[47] ? en_exp[7:0] : 8'd0;
    s2_nxt.ovf  = s2_nxt.m[47] && (en_exp >= 11'sd255);
  end

  logic        inc;
  logic [30:0] packed_mag;

  always_comb begin
    inc = s2_r.m[23] && ((|s2_r.m[22:0]) || s2_r.sticky || s2_r.m[24]);
    packed_mag = {s2_r.expf, s2_r.m[46:24]} + {30'd0, inc};
    priority if (s2_r.nan) begin
      p_nxt = fisr_pkg::CANON_QNAN;
    end else if (s2_r.inf || s2_r.ovf) begin
      p_nxt = {s2_r.sign, 8'hFF, 23'd0};
    end else if (s2_r.zero) begin
      p_nxt = {s2_r.sign, 31'd0};
    end else begin
      p_nxt = {s2_r.sign, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== design/fisr_fadd.sv =====
// Four-stage binary32 adder: alignment, addition, normalisation, rounding to nearest even.
// Handles subnormals, infinities and NaNs; depends on fisr_pkg.
module fisr_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);

  typedef struct packed {
    logic       sign;
    logic       eff_sub;
    logic       nan;
    logic       inf;
    logic       inf_sign;
  } add_ctl_t;

  typedef struct packed {
    logic [26:0] lm;
    logic [26:0] sm;
    logic [7:0]  el;
    add_ctl_t    ctl;
  } add_s1_t;

  typedef struct packed {
    logic [27:0] sum;
    logic [7:0]  el;
    add_ctl_t    ctl;
  } add_s2_t;

  typedef struct packed {
    logic [26:0] n;
    logic [7:0]  expf;
    logic        ovf;
    logic        zero;
    add_ctl_t    ctl;
  } add_s3_t;

  function automatic logic [4:0] clz27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  add_s1_t s1_nxt, s1_r;
  add_s2_t s2_nxt, s2_r;
  add_s3_t s3_nxt, s3_r;
  logic [31:0] s_nxt, s_r;

  logic [31:0] big, sml;
  logic [7:0]  ebg, esm, ebg_e, esm_e, diff;
  logic [4:0]  ash;
  logic [26:0] sm_ext;
  logic        a_nan, b_nan, a_inf, b_inf;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    ebg   = big[30:23];
    esm   = sml[30:23];
    ebg_e = (ebg == 8'd0) ? 8'd1 : ebg;
    esm_e = (esm == 8'd0) ? 8'd1 : esm;
    diff  = ebg_e - esm_e;
    ash   = (diff > 8'd27) ? 5'd27 : diff[4:0];
    sm_ext = {(esm != 8'd0), sml[22:0], 3'b000};
    s1_nxt.lm = {(ebg != 8'd0), big[22:0], 3'b000};
    s1_nxt.sm = (sm_ext >> ash) |
                {26'd0, |(sm_ext & ~(27'h7FF_FFFF << ash))};
    s1_nxt.el = ebg_e;
    s1_nxt.ctl.sign     = big[31];
    s1_nxt.ctl.eff_sub  = a[31] ^ b[31];
    s1_nxt.ctl.nan      = a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
    s1_nxt.ctl.inf      = a_inf || b_inf;
    s1_nxt.ctl.inf_sign = a_inf ? a[31] : b[31];
  end

  always_comb begin
    if (s1_r.ctl.eff_sub) begin
      s2_nxt.sum = {1'b0, s1_r.lm} - {1'b0, s1_r.sm};
    end else begin
      s2_nxt.sum = {1'b0, s1_r.lm} + {1'b0, s1_r.sm};
    end
    s2_nxt.el  = s1_r.el;
    s2_nxt.ctl = s1_r.ctl;
  end

  logic [4:0] lz, lsh;
  logic [7:0] lim;
  logic [8:0] e9;

  always_comb begin
    lz  = clz27(s2_r.sum[26:0]);
    lim = s2_r.el - 8'd1;
    lsh = 5'd0;
    s3_nxt.ctl  = s2_r.ctl;
    s3_nxt.zero = (s2_r.sum == 28'd0);
    if (s2_r.sum[27]) begin
      s3_nxt.n = {s2_r.sum[27:2], s2_r.sum[1] | s2_r.sum[0]};
      e9 = {1'b0, s2_r.el} + 9'd1;
    end else begin
      lsh = ({3'b000, lz} < lim) ? lz : lim[4:0];
      s3_nxt.n = s2_r.sum[26:0] << lsh;
      e9 = {1'b0, s2_r.el} - {4'd0, lsh};
    end
    s3_nxt.expf = s3_nxt.n[26] ? e9[7:0] : 8'd0;
    s3_nxt.ovf  = (e9 >= 9'd255);
  end

  logic        inc;
  logic [30:0] packed_mag;

  always_comb begin
    inc = s3_r.n[2] && (s3_r.n[1] || s3_r.n[0] || s3_r.n[3]);
    packed_mag = {s3_r.expf, s3_r.n[25:3]} + {30'd0, inc};
    priority if (s3_r.ctl.nan) begin
      s_nxt = fisr_pkg::CANON_QNAN;
    end else if (s3_r.ctl.inf) begin
      s_nxt = {s3_r.ctl.inf_sign, 8'hFF, 23'd0};
    end else if (s3_r.zero) begin
      s_nxt = {s3_r.ctl.sign & ~s3_r.ctl.eff_sub, 31'd0};
    end else if (s3_r.ovf) begin
      s_nxt = {s3_r.ctl.sign, 8'hFF, 23'd0};
    end else begin
      s_nxt = {s3_r.ctl.sign, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s_r  <= s_nxt;
    end
  end

  assign s = s_r;

endmodule

// ===== design/fast_inverse_sqrt.sv =====
// Top level of the fast inverse square root block: guess stage and floating pipeline.
// Depends on fisr_pkg, fisr_in_if, fisr_out_if, fisr_fmul and fisr_fadd.
//
// Usage: operand items arrive on in_ch as binary32 bit patterns, and for each one
// item leaves on out_ch carrying the approximate reciprocal square root, in order.
// The integer guess is formed in the first stage, then the products r*r and x*0.5,
// the product with the half value, the subtraction from 1.5 and the final product
// follow in pipelined floating units.
// From acceptance to the result being shown on out_ch, an item passes one guess stage,
// three multiplier passes of three stages and one adder of four stages.
// Throughput is one item per cycle while out_ch is not stalled; every stage has its own valid bit.
// The whole pipeline advances together whenever the last stage is empty or
// out_ch is ready, so a stall of the receiver holds every item in place and
// in_ch.ready falls only while the output holds an item that is not taken.
// Reset clears all valid bits; no item is in flight afterwards.
// A NaN result is always delivered as the canonical quiet NaN.
module fast_inverse_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  fisr_in_if.sink           in_ch,
  fisr_out_if.source        out_ch
);

  localparam int unsigned LAT = fisr_pkg::LATENCY;
  localparam int unsigned RDL = fisr_pkg::R_DELAY;

  logic           adv;
  logic [LAT-1:0] vld_r;
  logic [31:0]    x_r;
  logic [31:0]    g_r;
  logic [31:0]    g_nxt;
  logic [31:0]    r_line_r [RDL];
  logic [31:0]    y_w, rr_w, t_w, d_w, res_w;

  assign adv = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign g_nxt = fisr_pkg::GUESS_MAGIC - {in_ch.operand_bits[31], in_ch.operand_bits[31:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= in_ch.operand_bits;
      g_r <= g_nxt;
      r_line_r[0] <= g_r;
      for (int i = 1; i < RDL; i++) begin
        r_line_r[i] <= r_line_r[i-1];
      end
    end
  end

  fisr_fmul u_mul_half (
    .clk (clk), .en (adv), .a (x_r), .b (fisr_pkg::F32_HALF), .p (y_w)
  );

  fisr_fmul u_mul_sq (
    .clk (clk), .en (adv), .a (g_r), .b (g_r), .p (rr_w)
  );

  fisr_fmul u_mul_t (
    .clk (clk), .en (adv), .a (rr_w), .b (y_w), .p (t_w)
  );

  fisr_fadd u_sub (
    .clk (clk), .en (adv), .a (fisr_pkg::F32_THREE_HALVES),
    .b ({~t_w[31], t_w[30:0]}), .s (d_w)
  );

  fisr_fmul u_mul_out (
    .clk (clk), .en (adv), .a (r_line_r[RDL-1]), .b (d_w), .p (res_w)
  );

  assign out_ch.valid       = vld_r[LAT-1];
  assign out_ch.result_bits = res_w;

endmodule

// ===== design/fisr_checker.sv =====
// Port-level checker for the fast inverse square root block, with its bind statement.
// Depends on fisr_pkg and on the top level fast_inverse_sqrt.
module fisr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(result_bits))
    else $error("Stalled result item changed.");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("Input blocked although the output can move.");

  a_canon_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_bits[30:23] == 8'hFF) |->
      (result_bits[22:0] == 23'd0) || (result_bits == fisr_pkg::CANON_QNAN))
    else $error("Result NaN is not canonical.");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("Result item shown straight after reset.");

endmodule

bind fast_inverse_sqrt fisr_checker u_fisr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_bits (out_ch.result_bits)
);
